FILE: rtl/weighted_admission_pool_defines.svh
// ---------------------------------------------------------------------------
// weighted_admission_pool_defines
// Assertion macros shared by the pool RTL.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_ADMISSION_POOL_DEFINES_SVH
`define WEIGHTED_ADMISSION_POOL_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define WAP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define WAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/wap_pkg.sv
// ---------------------------------------------------------------------------
// wap_pkg
// Types and constants of the weighted admission pool.
// ---------------------------------------------------------------------------
package wap_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int MAX_RELEASE     = 16;

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_FINISH   = 2'd1,
        ACT_DELAY    = 2'd2,
        ACT_RETRIEVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2,
        ST_DUP  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_REL,
        S_COMPACT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] job_id;
        logic [15:0] job_weight;
    } in_item_t;

    typedef struct packed {
        logic        released;
        logic [15:0] out_id;
        logic [15:0] out_weight;
        logic [15:0] use_now;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

endpackage

FILE: rtl/wap_ram.sv
// ---------------------------------------------------------------------------
// wap_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module wap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/weighted_admission_pool.sv
// ---------------------------------------------------------------------------
// Weighted admission pool
// Input channel in_valid/in_stall carries one in_item_t per transfer; the
// output channel out_valid/out_stall carries out_item_t results. Schedule,
// finish and delay give one result; retrieve gives one result per released
// job (up to 16) or a single empty result, with last marking the final one.
// The queue lives in one RAM of QUEUE_DEPTH entries (id and weight) with
// one access a cycle and a registered read; that port sets the timing.
// Schedule and finish go from the transfer to S_OUT, which presents the result.
// A delay scans the queue with one read per entry, moves each entry behind
// the slot up by one with a read and a write, writes the new entry and
// presents the result in S_OUT. A retrieve reads the candidate heads,
// compacts the remaining entries with a read and a write each, and ends in S_OUT.
// One item is in work at a time: the input is stalled while busy and while
// a result waits, so the next transfer can come only after the final
// result leaves.
// Reset clears the use, the count and the capacity register; the RAM is
// not cleared, since entries beyond the count are never read as data.
// A stalled result is held in the output register and the walk waits.
// ---------------------------------------------------------------------------
module weighted_admission_pool
    import wap_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [15:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
`include "weighted_admission_pool_defines.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int UW = 17;
    localparam int REL_LIM = (MAX_RELEASE < QUEUE_DEPTH) ? MAX_RELEASE : QUEUE_DEPTH;
    localparam logic [15:0] WMASK = 16'((32'h1 << WEIGHT_BITS) - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] REL_C = CW'(REL_LIM);

    state_t state_reg, state_next;
    logic [15:0] cap_reg;
    logic [15:0] use_reg, use_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;      // Scan / shift / compact index.
    logic [CW-1:0] pos_reg, pos_next;      // Insert position or release count.
    logic          pos_found_reg, pos_found_next;
    logic          dup_reg, dup_next;
    status_t       st_reg, st_next;
    in_item_t      item_reg, item_next;
    logic          rd_pend_reg, rd_pend_next;
    out_item_t     out_reg, out_next;
    out_item_t     hold_reg, hold_next;
    logic          ov_reg, ov_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;
    logic [15:0]   rd_id, rd_w, in_w;
    logic [UW-1:0] sum_use;

    wap_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign rd_id  = rd_data[31:16];
    assign rd_w   = rd_data[15:0];
    assign in_w   = item_reg.job_weight & WMASK;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Control and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            use_reg       <= '0;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            use_reg       <= use_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        pos_found_reg <= pos_found_next;
        dup_reg       <= dup_next;
        st_reg        <= st_next;
        item_reg      <= item_next;
        out_reg       <= out_next;
        hold_reg      <= hold_next;
    end

    // Next state, RAM access and results.
    always_comb
    begin
        logic [UW-1:0] s;
        logic          out_free;
        state_next     = state_reg;
        use_next       = use_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        dup_next       = dup_reg;
        st_next        = st_reg;
        item_next      = item_reg;
        rd_pend_next   = 1'b0;
        out_next       = out_reg;
        hold_next      = hold_reg;
        ov_next        = ov_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_addr        = '0;
        sum_use        = '0;
        s              = '0;
        out_free       = !ov_reg || !out_stall;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    item_next      = in_data;
                    idx_next       = '0;
                    pos_next       = cnt_reg;
                    pos_found_next = 1'b0;
                    dup_next       = 1'b0;
                    st_next        = ST_OK;
                    case (action_t'(in_data.action))
                        ACT_SCHEDULE, ACT_FINISH: state_next = S_OUT;
                        ACT_DELAY:    state_next = S_SCAN;
                        ACT_RETRIEVE:
                        begin
                            pos_next   = '0;
                            state_next = S_REL;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN:
            begin
                // One read issued a cycle; compare the entry read last cycle.
                if (rd_pend_reg)
                begin
                    if (rd_id == item_reg.job_id)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!pos_found_reg && !((rd_w < in_w) ||
                        (rd_w == in_w && rd_id < item_reg.job_id)))
                    begin
                        pos_found_next = 1'b1;
                        pos_next       = idx_reg - CW'(1);
                    end
                end
                if (cap_reg == '0 || idx_reg >= cnt_reg)
                begin
                    if (cap_reg != '0 && !dup_next && cnt_reg < DEPTH_C)
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        // Dropped: zero capacity first, then duplicate, then full.
                        if (cap_reg == '0)
                            st_next = ST_ZERO;
                        else if (dup_next)
                            st_next = ST_DUP;
                        else
                            st_next = ST_FULL;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    rd_addr      = idx_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end
            end
            S_SHIFT:
            begin
                // Move entry idx-1 to idx, from the tail down to the slot.
                if (rd_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = rd_data;
                    idx_next = idx_reg - CW'(1);
                end
                else if (idx_reg > pos_reg)
                begin
                    rd_addr      = AW'(idx_reg - CW'(1));
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[AW-1:0];
                    wr_data  = {item_reg.job_id, in_w};
                    cnt_next = cnt_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_REL:
            begin
                // Head candidates are read one after another. Each fitting job is
                // held until the next one fits or the walk ends, so that the
                // final release can carry last.
                if (rd_pend_reg)
                begin
                    sum_use = {1'b0, use_reg} + {1'b0, rd_w};
                    if (sum_use > {1'b0, cap_reg})
                    begin
                        state_next = S_COMPACT;
                        idx_next   = '0;
                    end
                    else if (pos_reg == '0 || out_free)
                    begin
                        if (cap_reg != '0)
                        begin
                            s = sum_use;
                            use_next = (s > {1'b0, WMASK}) ? WMASK : s[15:0];
                        end
                        if (pos_reg != '0)
                        begin
                            out_next = hold_reg;
                            ov_next  = 1'b1;
                        end
                        hold_next = '{released: 1'b1, out_id: rd_id, out_weight: rd_w,
                                      use_now: use_next, status: ST_OK, last: 1'b0};
                        pos_next  = pos_reg + CW'(1);
                    end
                    else
                    begin
                        rd_addr      = pos_reg[AW-1:0];
                        rd_pend_next = 1'b1;
                    end
                end
                else if (pos_reg < cnt_reg && pos_reg < REL_C &&
                         !(ov_reg && out_stall))
                begin
                    rd_addr      = pos_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                end
                else if (pos_reg >= cnt_reg || pos_reg >= REL_C)
                begin
                    state_next = S_COMPACT;
                    idx_next   = '0;
                end
            end
            S_COMPACT:
            begin
                // Copy entry idx+n down to idx by a read and then a write, n being the release count.
                if (rd_pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_reg + CW'(1);
                end
                else if (pos_reg != '0 && idx_reg + pos_reg < cnt_reg)
                begin
                    rd_addr      = AW'(idx_reg + pos_reg);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg - pos_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Final result of the item.
                if (out_free)
                begin
                    out_next = '{released: 1'b0, out_id: '0, out_weight: '0,
                                 use_now: use_reg, status: ST_OK, last: 1'b1};
                    case (action_t'(item_reg.action))
                        ACT_SCHEDULE:
                        begin
                            if (cap_reg != '0)
                            begin
                                s = {1'b0, use_reg} + {1'b0, in_w};
                                use_next = (s > {1'b0, WMASK}) ? WMASK : s[15:0];
                            end
                        end
                        ACT_FINISH:
                        begin
                            if (cap_reg != '0)
                            begin
                                use_next = (use_reg > in_w) ? use_reg - in_w : '0;
                            end
                        end
                        ACT_DELAY:
                        begin
                            out_next.status = st_reg;
                        end
                        default: ;
                    endcase
                    out_next.use_now = use_next;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                    // A retrieve that released jobs ends with its held release.
                    if (action_t'(item_reg.action) == ACT_RETRIEVE && pos_reg != '0)
                    begin
                        out_next      = hold_reg;
                        out_next.last = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `WAP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= DEPTH_C, "queue count beyond depth")
    `WAP_ASSERT_IMP(a_busy_stall, state_reg != S_IDLE, in_stall, "input taken while busy")
    `WAP_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(out_data),
                     "stalled result changed")

endmodule

FILE: tb/sv/weighted_admission_pool_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Weighted admission pool testbench
// Sends schedule, finish, delay and retrieve requests through the input
// channel under random idling and stalls. A model of the use counter and the
// sorted wait queue inside this file predicts every result, and each result
// is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module weighted_admission_pool_tb;
    import wap_pkg::*;

    localparam int QDEPTH  = DEF_QUEUE_DEPTH;
    localparam int MAX_USE = 65535;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;

    // Pool model state.
    int unsigned pool_cap;
    int unsigned pool_use;
    logic [15:0] q_id [QDEPTH];
    logic [15:0] q_wt [QDEPTH];
    int          q_cnt;

    out_item_t   pending_results [$];
    int          fail_count = 0;
    bit          calm = 1'b0;

    weighted_admission_pool dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #5 clk = ~clk;

    // Generous overall time limit.
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        fail_count++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Appends one expected result at the tail of the queue.
    task automatic expect_result(input out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    function automatic out_item_t make_result(input logic rel, input logic [15:0] id,
                                              input logic [15:0] wt,
                                              input status_t st, input logic lst);
        out_item_t r;
        r.released   = rel;
        r.out_id     = id;
        r.out_weight = wt;
        r.use_now    = pool_use[15:0];
        r.status     = st;
        r.last       = lst;
        return r;
    endfunction

    // Predicts the results of one request and queues them.
    task automatic predict_pool(input in_item_t it);
        int      pos;
        int      n;
        status_t st;
        out_item_t r;
        case (action_t'(it.action))
            ACT_SCHEDULE:
            begin
                if (pool_cap != 0)
                    pool_use = (pool_use + it.job_weight > MAX_USE) ? MAX_USE
                               : pool_use + it.job_weight;
                expect_result(make_result(1'b0, '0, '0, ST_OK, 1'b1));
            end
            ACT_FINISH:
            begin
                if (pool_cap != 0)
                    pool_use = (pool_use > it.job_weight) ? pool_use - it.job_weight : 0;
                expect_result(make_result(1'b0, '0, '0, ST_OK, 1'b1));
            end
            ACT_DELAY:
            begin
                st = ST_OK;
                if (pool_cap == 0)
                    st = ST_ZERO;
                else
                begin
                    for (int i = 0; i < q_cnt; i++)
                        if (q_id[i] == it.job_id)
                            st = ST_DUP;
                    if (st == ST_OK && q_cnt >= QDEPTH)
                        st = ST_FULL;
                end
                if (st == ST_OK)
                begin
                    pos = 0;
                    while (pos < q_cnt && (q_wt[pos] < it.job_weight ||
                           (q_wt[pos] == it.job_weight && q_id[pos] < it.job_id)))
                        pos++;
                    for (int i = q_cnt; i > pos; i--)
                    begin
                        q_id[i] = q_id[i-1];
                        q_wt[i] = q_wt[i-1];
                    end
                    q_id[pos] = it.job_id;
                    q_wt[pos] = it.job_weight;
                    q_cnt++;
                end
                expect_result(make_result(1'b0, '0, '0, st, 1'b1));
            end
            default:
            begin
                n = 0;
                while (n < MAX_RELEASE && n < q_cnt && pool_use + q_wt[n] <= pool_cap)
                begin
                    if (pool_cap != 0)
                        pool_use = (pool_use + q_wt[n] > MAX_USE) ? MAX_USE
                                   : pool_use + q_wt[n];
                    r = make_result(1'b1, q_id[n], q_wt[n], ST_OK, n + 1 == q_cnt);
                    expect_result(r);
                    n++;
                end
                if (n == 0)
                    expect_result(make_result(1'b0, '0, '0, ST_OK, 1'b1));
                else
                begin
                    // Only the final release carries last.
                    for (int i = 0; i < n; i++)
                        pending_results[pending_results.size() - n + i].last = (i == n - 1);
                    for (int i = 0; i + n < q_cnt; i++)
                    begin
                        q_id[i] = q_id[i+n];
                        q_wt[i] = q_wt[i+n];
                    end
                    q_cnt -= n;
                end
            end
        endcase
    endtask

    // Result checking and output stall generation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result", 16'h0000, 16'h0000);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.released !== want.released)
                    report("released", {15'h0, out_data.released}, {15'h0, want.released});
                if (out_data.out_id !== want.out_id)
                    report("out_id", out_data.out_id, want.out_id);
                if (out_data.out_weight !== want.out_weight)
                    report("out_weight", out_data.out_weight, want.out_weight);
                if (out_data.use_now !== want.use_now)
                    report("use_now", out_data.use_now, want.use_now);
                if (out_data.status !== want.status)
                    report("status", {14'h0, out_data.status}, {14'h0, want.status});
                if (out_data.last !== want.last)
                    report("last", {15'h0, out_data.last}, {15'h0, want.last});
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Presents one request and holds it until the transfer. Valid stays up
    // after the transfer until the next request or an idle burst.
    task automatic send_item(input action_t act, input logic [15:0] id,
                             input logic [15:0] wt);
        in_item_t it;
        it.action     = act;
        it.job_id     = id;
        it.job_weight = wt;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pool(it);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pool_cap = value;
    endtask

    // Directed requests; each row gives the expected status and use.
    typedef struct {
        action_t     act;
        logic [15:0] id;
        logic [15:0] wt;
        status_t     want_st;
        logic [15:0] want_use;
    } row_t;

    // Sends a table of rows and checks the typed expectations.
    task automatic run_rows(input row_t tbl [$]);
        foreach (tbl[i])
        begin
            send_item(tbl[i].act, tbl[i].id, tbl[i].wt);
            if (pending_results[$].status !== tbl[i].want_st)
                report("typed status", {14'h0, pending_results[$].status},
                       {14'h0, tbl[i].want_st});
            if (pending_results[$].use_now !== tbl[i].want_use)
                report("typed use", pending_results[$].use_now, tbl[i].want_use);
        end
    endtask

    initial
    begin
        row_t        rows [$];
        logic [15:0] caps [5];
        action_t     act;
        int          pick;
        pool_cap = 0;
        pool_use = 0;
        q_cnt    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Capacity zero: use is untracked and delays are dropped.
        rows = '{'{ACT_SCHEDULE, 16'h0001, 16'hFFFF, ST_OK,   16'h0000},
                 '{ACT_FINISH,   16'h0002, 16'hFFFF, ST_OK,   16'h0000},
                 '{ACT_DELAY,    16'h0003, 16'h0000, ST_ZERO, 16'h0000},
                 '{ACT_RETRIEVE, 16'hFFFF, 16'hFFFF, ST_OK,   16'h0000}};
        run_rows(rows);

        // Maximum capacity: saturation, duplicates, full queue and release limit.
        set_capacity(16'hFFFF);
        rows = '{'{ACT_SCHEDULE, 16'h0000, 16'hFFFF, ST_OK,  16'hFFFF},
                 '{ACT_SCHEDULE, 16'h0000, 16'h0010, ST_OK,  16'hFFFF},
                 '{ACT_FINISH,   16'h0000, 16'h0005, ST_OK,  16'hFFFA},
                 '{ACT_FINISH,   16'h0000, 16'hFFFF, ST_OK,  16'h0000},
                 '{ACT_FINISH,   16'h0000, 16'h0001, ST_OK,  16'h0000},
                 '{ACT_DELAY,    16'hFFFF, 16'h0000, ST_OK,  16'h0000},
                 '{ACT_DELAY,    16'hFFFF, 16'h0009, ST_DUP, 16'h0000},
                 '{ACT_DELAY,    16'h0000, 16'h0000, ST_OK,  16'h0000},
                 '{ACT_DELAY,    16'hAAAA, 16'h5555, ST_OK,  16'h0000},
                 '{ACT_DELAY,    16'h5555, 16'hAAAA, ST_OK,  16'h0000}};
        run_rows(rows);
        for (int i = 0; i < 14; i++)
            send_item(ACT_DELAY, 16'h0100 + 16'(i), 16'h0003);
        send_item(ACT_DELAY, 16'h0777, 16'h0001);
        send_item(ACT_RETRIEVE, 16'h0000, 16'h0000);
        send_item(ACT_RETRIEVE, 16'h0000, 16'h0000);

        // Random phases over several capacities, small ones included.
        caps = '{16'd1, 16'd40, 16'd300, 16'd0, 16'd65535};
        foreach (caps[c])
        begin
            set_capacity(caps[c]);
            if (c == 2)
                drain_results();
            for (int i = 0; i < 75; i++)
            begin
                calm = (c == 4 && i > 50);
                pick = $urandom_range(0, 9);
                act = (pick < 4) ? ACT_DELAY : (pick < 6) ? ACT_RETRIEVE
                      : (pick < 8) ? ACT_FINISH : ACT_SCHEDULE;
                if ($urandom_range(0, 7) == 0)
                    send_item(act, 16'($urandom), 16'($urandom));
                else
                    send_item(act, 16'($urandom_range(0, 31)), 16'($urandom_range(0, 30)));
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: weighted_admission_pool.f
+incdir+rtl
rtl/wap_pkg.sv
rtl/wap_ram.sv
rtl/weighted_admission_pool.sv
tb/sv/weighted_admission_pool_tb.sv
